// ===== hdl/base64_char_decoder_top_defines.svh =====
// Assertion macros used by the base64 character decoder checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BASE64_CHAR_DECODER_TOP_DEFINES_SVH
`define BASE64_CHAR_DECODER_TOP_DEFINES_SVH

// Assertion that is switched off while reset is high
`define B64D_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds across reset
`define B64D_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/b64d_pkg.sv =====
// Types, character constants and the alphabet lookup of the base64 decoder.
// No dependencies; imported by the decoder top level, its checker and the testbench.
`timescale 1ns / 1ps

package b64d_pkg;

   // one encoded character
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   // one decoded result
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_string;
      logic       bad_input;
   } rsp_type;

   // lookup result: known flag and sextet value
   typedef struct packed {
      logic       known;
      logic [5:0] value;
   } sextet_type;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;

   localparam logic [5:0] SEXTET_LO_BASE  = 6'd26;
   localparam logic [5:0] SEXTET_DIG_BASE = 6'd52;
   localparam logic [5:0] SEXTET_62       = 6'd62;
   localparam logic [5:0] SEXTET_63       = 6'd63;

   // place of a character within its group of four
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;
   localparam logic [1:0] PHASE_FOURTH = 2'd3;

   // map a character of either alphabet to its sextet
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      logic [7:0] d;
      s = '0;
      d = '0;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         d = c - CHAR_UP_A;
         s = '{known: 1'b1, value: d[5:0]};
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         d = c - CHAR_LO_A;
         s = '{known: 1'b1, value: d[5:0] + SEXTET_LO_BASE};
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
         s = '{known: 1'b1, value: d[5:0] + SEXTET_DIG_BASE};
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         s = '{known: 1'b1, value: SEXTET_62};
      end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
         s = '{known: 1'b1, value: SEXTET_63};
      end
      return s;
   endfunction

endpackage

// ===== hdl/base64_char_decoder_top.sv =====
// Base64 character decoder top level: input register, decode, result register.
// Depends on b64d_pkg for item types, character codes and the alphabet lookup.
`timescale 1ns / 1ps

// Takes one base64 character per cycle (standard or URL-safe alphabet) and
// returns at most one result per character: a decoded byte, an end-of-string
// marker or an error flag. Throughput is one character every cycle while
// req_stall is low; a character passes the input register and then the result
// register, with the alphabet lookup and the group state update between them.
// The result register lets the next character enter while a result still
// waits; characters that produce no result pass through even while the
// result side stalls.
module base64_char_decoder_top
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   // input register
   logic       in_valid_ff;
   req_type    in_item_ff;

   // group state
   logic [1:0] phase_ff,    phase_in;
   logic [5:0] held_ff,     held_in;
   logic       pad_seen_ff, pad_seen_in;
   logic       dropping_ff, dropping_in;

   // result register
   logic       out_valid_ff;
   rsp_type    out_item_ff;

   logic       emit;
   rsp_type    result;
   logic       advance;
   sextet_type sx;
   logic [7:0] dec_byte;
   logic       is_pad;
   logic       last;

   assign last   = in_item_ff.last_char;
   assign sx     = sextet_of(in_item_ff.char_code);
   assign is_pad = (in_item_ff.char_code == PAD_CHAR);

   // assemble the byte completed at this place in the group
   always_comb begin
      case (phase_ff)
         PHASE_SECOND: dec_byte = {held_ff, sx.value[5:4]};
         PHASE_THIRD:  dec_byte = {held_ff[3:0], sx.value[5:2]};
         default:      dec_byte = {held_ff[1:0], sx.value};
      endcase
   end

   // decide result and next group state
   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      pad_seen_in = pad_seen_ff;
      dropping_in = dropping_ff;
      emit        = 1'b0;
      result      = '0;
      if (dropping_ff) begin
         // drop up to the last character of the string
         emit                 = last;
         result.end_of_string = 1'b1;
         if (last) begin
            phase_in    = PHASE_FIRST;
            held_in     = '0;
            pad_seen_in = 1'b0;
            dropping_in = 1'b0;
         end
      end else if (phase_ff == PHASE_FOURTH && pad_seen_ff) begin
         // fourth place after a third-place pad: skip unchecked
         emit                 = last;
         result.end_of_string = 1'b1;
         phase_in             = PHASE_FIRST;
         held_in              = '0;
         pad_seen_in          = 1'b0;
      end else if (is_pad && (phase_ff == PHASE_THIRD || phase_ff == PHASE_FOURTH)) begin
         if (phase_ff == PHASE_THIRD && !last) begin
            phase_in    = PHASE_FOURTH;
            pad_seen_in = 1'b1;
         end else begin
            phase_in    = PHASE_FIRST;
            held_in     = '0;
            pad_seen_in = 1'b0;
         end
         emit                 = last;
         result.end_of_string = 1'b1;
         result.bad_input     = (phase_ff != PHASE_FOURTH);
      end else if (!sx.known) begin
         // unknown character: report and drop the rest
         emit                 = 1'b1;
         result.end_of_string = last;
         result.bad_input     = 1'b1;
         phase_in             = PHASE_FIRST;
         held_in              = '0;
         pad_seen_in          = 1'b0;
         dropping_in          = !last;
      end else if (last) begin
         // string ends: valid only on a full group
         emit                 = 1'b1;
         result.end_of_string = 1'b1;
         if (phase_ff == PHASE_FOURTH) begin
            result.data_byte  = dec_byte;
            result.byte_valid = 1'b1;
         end else begin
            result.bad_input  = 1'b1;
         end
         phase_in    = PHASE_FIRST;
         held_in     = '0;
         pad_seen_in = 1'b0;
      end else begin
         // ordinary character: hold sextet and advance place
         emit              = (phase_ff != PHASE_FIRST);
         result.data_byte  = dec_byte;
         result.byte_valid = 1'b1;
         phase_in          = phase_ff + 2'd1;
         if (phase_ff == PHASE_FOURTH) begin
            held_in     = '0;
            pad_seen_in = 1'b0;
         end else begin
            held_in     = sx.value;
         end
      end
   end

   // an item moves on unless its result would overwrite a waiting one
   assign advance   = in_valid_ff && (!emit || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   // group state advances with each decoded item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_FIRST;
         held_ff     <= '0;
         pad_seen_ff <= 1'b0;
         dropping_ff <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         pad_seen_ff <= pad_seen_in;
         dropping_ff <= dropping_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ===== hdl/b64d_checker.sv =====
// Port-level checker for the base64 character decoder, bound to its top level.
// Depends on b64d_pkg and the assertion macros in base64_char_decoder_top_defines.svh.
`timescale 1ns / 1ps
`include "base64_char_decoder_top_defines.svh"

module b64d_checker
   import b64d_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_item,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);

   logic req_taken;
   assign req_taken = req_valid && !req_stall;

   // no result is pending right after reset
   `B64D_ASSERT(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // a stalled result holds
   `B64D_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item), "stalled item changed")

   // a decoded byte is never flagged bad
   `B64D_ASSERT_RST(a_byte_not_bad, clock, reset, rsp_valid && rsp_item.byte_valid |-> !rsp_item.bad_input, "byte flagged bad")

   // results without a byte carry a zero byte
   `B64D_ASSERT_RST(a_empty_zero, clock, reset, rsp_valid && !rsp_item.byte_valid |-> rsp_item.data_byte == 8'h00, "nonzero byte without byte_valid")

   // a last character taken while no result waits, once it moves on, ends the string
   `B64D_ASSERT_RST(a_last_ends, clock, reset, req_taken && req_item.last_char && !rsp_valid ##1 !req_stall |=> rsp_valid && rsp_item.end_of_string, "last character gave no end result")

endmodule

bind base64_char_decoder_top b64d_checker u_b64d_checker (.*);

// ===== tb/tb_base64_char_decoder_top.sv =====
// Self-checking testbench for the base64 character decoder top level.
// Depends on b64d_pkg for the item types and character codes, and on the RTL.
`timescale 1ns / 1ps

module tb_base64_char_decoder_top;
   import b64d_pkg::*;

   // one queued character plus its pacing controls
   typedef struct {
      req_type item;
      bit      calm;        // no idling on either side while this item is current
      bit      drain_first; // hold until every expected result has arrived
   } char_slot_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   char_slot_type pending_chars[$];
   rsp_type       expected_results[$];
   int            error_count = 0;
   int            char_total = 0;
   bit            fill_calm = 1'b0;
   bit            fill_drain = 1'b0;
   bit            calm_now = 1'b0;
   int            send_gap = 0;
   int            stall_left = 0;

   // decoder state as predicted from the outside
   logic [1:0] dec_phase;
   logic [5:0] dec_held;
   logic       dec_pad;
   logic       dec_drop;

   base64_char_decoder_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // return to the start of a string
   function automatic void clear_decoder();
      dec_phase = PHASE_FIRST;
      dec_held  = '0;
      dec_pad   = 1'b0;
      dec_drop  = 1'b0;
   endfunction

   // map a character of either alphabet; returns 0 for anything else
   function automatic bit char_to_sextet(input logic [7:0] c, output logic [5:0] v);
      logic [7:0] d;
      d = '0;
      v = '0;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         d = c - CHAR_UP_A;
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         d = c - CHAR_LO_A + 8'd26;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO + 8'd52;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         d = 8'd62;
      end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
         d = 8'd63;
      end else begin
         return 1'b0;
      end
      v = d[5:0];
      return 1'b1;
   endfunction

   // advance the predicted state by one character; returns 1 if it yields a result
   function automatic bit decode_char(input req_type r, output rsp_type o);
      logic [1:0] ph;
      logic [5:0] v;
      logic [7:0] b;
      bit         have;
      bit         last;
      ph   = dec_phase;
      v    = '0;
      b    = '0;
      have = 1'b1;
      last = r.last_char;
      o    = '0;

      // drop everything after an error until the string ends
      if (dec_drop) begin
         if (!last) return 1'b0;
         clear_decoder();
         o.end_of_string = 1'b1;
         return 1'b1;
      end

      // fourth place after a third-place pad is skipped unchecked
      if (ph == PHASE_FOURTH && dec_pad) begin
         clear_decoder();
         if (!last) return 1'b0;
         o.end_of_string = 1'b1;
         return 1'b1;
      end

      // pad in the third or fourth place
      if (r.char_code == PAD_CHAR && (ph == PHASE_THIRD || ph == PHASE_FOURTH)) begin
         if (ph == PHASE_THIRD) begin
            dec_phase = PHASE_FOURTH;
            dec_pad   = 1'b1;
         end else begin
            clear_decoder();
         end
         if (!last) return 1'b0;
         clear_decoder();
         o.end_of_string = 1'b1;
         o.bad_input     = (ph != PHASE_FOURTH);
         return 1'b1;
      end

      // unknown character: report, then drop unless it ends the string
      if (!char_to_sextet(r.char_code, v)) begin
         clear_decoder();
         dec_drop        = !last;
         o.end_of_string = last;
         o.bad_input     = 1'b1;
         return 1'b1;
      end

      case (ph)
         PHASE_FIRST: have = 1'b0;
         PHASE_SECOND: b = {dec_held, v[5:4]};
         PHASE_THIRD: b = {dec_held[3:0], v[5:2]};
         default: b = {dec_held[1:0], v};
      endcase

      // a string must end on the fourth place of a group
      if (last) begin
         clear_decoder();
         o.end_of_string = 1'b1;
         if (ph != PHASE_FOURTH) begin
            o.bad_input = 1'b1;
         end else begin
            o.data_byte  = b;
            o.byte_valid = 1'b1;
         end
         return 1'b1;
      end

      dec_held  = v;
      dec_phase = ph + 2'd1;
      if (dec_phase == PHASE_FIRST) begin
         dec_held = '0;
         dec_pad  = 1'b0;
      end
      if (!have) return 1'b0;
      o.data_byte  = b;
      o.byte_valid = 1'b1;
      return 1'b1;
   endfunction

   // driver: record accepted items, then present the next one or idle
   always @(posedge clock) begin
      rsp_type       r;
      char_slot_type s;
      if (reset) begin
         req_valid <= 1'b0;
         clear_decoder();
      end else begin
         if (req_valid && !req_stall) begin
            if (decode_char(req_item, r)) expected_results.insert(expected_results.size(), r);
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_chars.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_chars[0].drain_first && expected_results.size() != 0) begin
               req_valid <= 1'b0;
            end else if (!pending_chars[0].calm && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else begin
               s = pending_chars.pop_front();
               req_item  <= s.item;
               req_valid <= 1'b1;
               calm_now  <= s.calm;
            end
         end
      end
   end

   // result side backpressure in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm_now && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: data_byte %h byte_valid %b end_of_string %b bad_input %b",
                   rsp_item.data_byte, rsp_item.byte_valid, rsp_item.end_of_string,
                   rsp_item.bad_input);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_item.data_byte !== want.data_byte) begin
               $error("data_byte: expected %h, actual %h", want.data_byte, rsp_item.data_byte);
               error_count++;
            end
            if (rsp_item.byte_valid !== want.byte_valid) begin
               $error("byte_valid: expected %b, actual %b", want.byte_valid,
                      rsp_item.byte_valid);
               error_count++;
            end
            if (rsp_item.end_of_string !== want.end_of_string) begin
               $error("end_of_string: expected %b, actual %b", want.end_of_string,
                      rsp_item.end_of_string);
               error_count++;
            end
            if (rsp_item.bad_input !== want.bad_input) begin
               $error("bad_input: expected %b, actual %b", want.bad_input, rsp_item.bad_input);
               error_count++;
            end
         end
      end
   end

   // queue one character
   task automatic add_char(input logic [7:0] c, input bit last);
      char_slot_type s;
      s.item.char_code = c;
      s.item.last_char = last;
      s.calm           = fill_calm;
      s.drain_first    = fill_drain;
      fill_drain       = 1'b0;
      pending_chars.insert(pending_chars.size(), s);
      char_total++;
   endtask

   // queue a whole string, last flag on its final character
   task automatic add_text(input string t);
      for (int i = 0; i < t.len(); i++) add_char(t[i], i == t.len() - 1);
   endtask

   function automatic logic [7:0] pick_alpha();
      int k;
      k = $urandom_range(0, 65);
      if (k < 26) return CHAR_UP_A + 8'(k);
      if (k < 52) return CHAR_LO_A + 8'(k - 26);
      if (k < 62) return CHAR_ZERO + 8'(k - 52);
      case (k)
         62: return CHAR_PLUS;
         63: return CHAR_MINUS;
         64: return CHAR_SLASH;
         default: return CHAR_UNDER;
      endcase
   endfunction

   function automatic logic [7:0] pick_noise();
      if ($urandom_range(0, 3) == 0) return PAD_CHAR;
      return 8'($urandom_range(0, 255));
   endfunction

   // build one random string: mostly well formed, some broken or noisy
   task automatic add_random_string();
      logic [7:0] s[$];
      int         kind;
      int         groups;
      int         pads;
      int         cut;
      kind   = $urandom_range(0, 9);
      groups = $urandom_range(1, 4);
      if (kind == 9) begin
         // pure noise
         repeat ($urandom_range(1, 8)) s.insert(s.size(), pick_noise());
      end else begin
         for (int g = 0; g < groups; g++) begin
            for (int j = 0; j < 4; j++) s.insert(s.size(), pick_alpha());
            // pad the final group, or now and then an inner one
            if (g == groups - 1 || (kind == 6 && $urandom_range(0, 2) == 0)) begin
               pads = $urandom_range(0, 2);
               if (pads >= 1) s[s.size() - 1] = PAD_CHAR;
               if (pads == 2) begin
                  s[s.size() - 2] = PAD_CHAR;
                  // odd character in the skipped fourth place
                  if ($urandom_range(0, 3) == 0) s[s.size() - 1] = pick_noise();
               end
            end
         end
         if (kind == 7) begin
            cut = $urandom_range(1, 3);
            repeat (cut) void'(s.pop_back());
         end
         if (kind == 8) s[$urandom_range(0, s.size() - 1)] = pick_noise();
      end
      foreach (s[i]) add_char(s[i], i == s.size() - 1);
   endtask

   // stimulus and end of run
   initial begin
      // directed: both alphabets, pads, skipped fourth place, short groups, errors
      add_text("zZ09-_+/");
      add_text("TQ=xTWE=");
      add_text("TQ==");
      add_text("=");
      add_text("TQ=");
      add_char(CHAR_UP_A, 1'b0);
      add_char(8'hFF, 1'b0);
      add_char(CHAR_UP_A + 8'd1, 1'b0);
      add_char(8'h00, 1'b1);

      // random strings, one drain pause at the start and more at random
      fill_drain = 1'b1;
      while (char_total < 1640) begin
         fill_calm = ($urandom_range(0, 9) == 0) || (char_total > 1500);
         if ($urandom_range(0, 39) == 0) fill_drain = 1'b1;
         add_random_string();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (pending_chars.size() != 0 || req_valid);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("** base64_char_decoder_top: PASSED **");
      end else begin
         $display("** base64_char_decoder_top: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("** base64_char_decoder_top: FAILED **");
      $finish;
   end

endmodule
